// ===== design/llh_pkg.sv =====
// Shared types and constants of the log2 latency histogram unit.
`timescale 1ns / 1ps

package llh_pkg;

    // Field widths of the request and response channels
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 8;
    localparam int STAMP_W  = 64;
    localparam int SEL_W    = 5;
    localparam int STATUS_W = 2;
    localparam int DUR_W    = 55;
    localparam int BIN_W    = 6;
    localparam int VALUE_W  = 64;

    // Divide-by-1000 unit: remainder always stays below the divisor
    localparam int NS_PER_US = 1000;
    localparam int REM_W     = 10;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_END    = 2'd1,
        CMD_RD_BIN = 2'd2,
        CMD_RD_MAX = 2'd3
    } t_cmd;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_START = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EVAL,
        S_DIV,
        S_BINRD,
        S_UPDATE,
        S_DONE
    } t_state;

    // Result of the divide unit
    typedef struct packed {
        logic               done;
        logic [STAMP_W-1:0] quot;
        logic [BIN_W-1:0]   msb;
    } t_div_res;

endpackage

// ===== design/llh_if.sv =====
// Request and response channel interfaces of the log2 latency histogram unit.
`timescale 1ns / 1ps

interface llh_in_if import llh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [STAMP_W-1:0]  stamp_ns;
    logic [SEL_W-1:0]    bin_select;

    modport source (output valid, cmd, slot, stamp_ns, bin_select, input ready);
    modport sink   (input valid, cmd, slot, stamp_ns, bin_select, output ready);
endinterface

interface llh_out_if import llh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DUR_W-1:0]    duration_us;
    logic [BIN_W-1:0]    bin_index;
    logic [VALUE_W-1:0]  read_value;
    logic                value_valid;

    modport source (output valid, status, duration_us, bin_index, read_value, value_valid,
                    input ready);
    modport sink   (input valid, status, duration_us, bin_index, read_value, value_valid,
                    output ready);
endinterface

// ===== design/latency_log2_histogram_unit.sv =====
// Top level of the log2 latency histogram unit: sequencer, slot memories and bin counters.
// Start and read requests, and end requests without a pending start, pass through the
// fetch and evaluate states to the done state. End requests with a pending start also
// pass through the divide, bin read and update states, and the divide runs through the
// 8 byte steps of the divide-by-1000 unit. The next request is accepted once the result
// sits in the output register. Reset (synchronous, active low) clears the bin valid marks
// at once, then sweeps the slot memories, during which no request is accepted.
`timescale 1ns / 1ps

module latency_log2_histogram_unit import llh_pkg::*; #(
    parameter int SLOTS = 256,
    parameter int BINS  = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    llh_in_if.sink     i_req,
    llh_out_if.source  o_rsp
);

    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BIN_AW  = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int STW     = STAMP_W + 1;
    localparam int MXW     = DUR_W + 1;

    t_state r_state, n_state;

    // Request and staging registers
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [STAMP_W-1:0]  r_stamp, n_stamp;
    logic [SEL_W-1:0]    r_sel, n_sel;
    logic                r_slot_ok, n_slot_ok;
    logic                r_sel_ok, n_sel_ok;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DUR_W-1:0]    r_dur, n_dur;
    logic [BIN_W-1:0]    r_bin, n_bin;
    logic [VALUE_W-1:0]  r_rv, n_rv;
    logic                r_vv, n_vv;
    logic [SLOT_AW-1:0]  r_clr, n_clr;
    logic [BINS-1:0]     r_bin_vld, n_bin_vld;

    // Output register
    logic                r_o_valid, n_o_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [DUR_W-1:0]    r_o_dur, n_o_dur;
    logic [BIN_W-1:0]    r_o_bin, n_o_bin;
    logic [VALUE_W-1:0]  r_o_rv, n_o_rv;
    logic                r_o_vv, n_o_vv;

    // Memory ports and control
    logic               w_accept, w_load, w_end_ok, w_bin_ok, w_max_upd;
    logic [SLOT_AW-1:0] w_slot_idx, w_slot_waddr;
    logic [BIN_AW-1:0]  w_sel_idx, w_bin_idx, w_bin_raddr;
    logic               w_st_we, w_st_re, w_mx_we, w_mx_re, w_bn_we, w_bn_re;
    logic [STW-1:0]     w_st_wdata, w_st_rdata;
    logic [MXW-1:0]     w_mx_wdata, w_mx_rdata;
    logic [VALUE_W-1:0] w_bn_wdata, w_bn_rdata, w_bn_cur;
    logic               w_div_start;
    logic [STAMP_W-1:0] w_diff;
    t_div_res           w_div;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_load     = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign w_slot_idx = SLOT_AW'(r_slot);
    assign w_sel_idx  = BIN_AW'(r_sel);
    assign w_bin_idx  = BIN_AW'(r_bin);
    assign w_end_ok   = r_slot_ok && w_st_rdata[STAMP_W];
    assign w_bin_ok   = ({1'b0, r_bin} < (BIN_W+1)'(BINS));
    assign w_max_upd  = !w_mx_rdata[DUR_W] || (r_dur > w_mx_rdata[DUR_W-1:0]);
    assign w_diff     = r_stamp - w_st_rdata[STAMP_W-1:0];
    assign w_bn_cur   = r_bin_vld[w_bin_idx] ? w_bn_rdata : '0;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == SLOT_AW'(SLOTS - 1)) n_state = S_IDLE;
            S_IDLE:   if (w_accept) n_state = S_FETCH;
            S_FETCH:  n_state = S_EVAL;
            S_EVAL:   n_state = (t_cmd'(r_cmd) == CMD_END && w_end_ok) ? S_DIV : S_DONE;
            S_DIV:    if (w_div.done) n_state = S_BINRD;
            S_BINRD:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   if (w_load) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Sequencer outputs: handshake, memory strobes, divider start
    always_comb begin
        i_req.ready  = 1'b0;
        w_st_we      = 1'b0;
        w_st_re      = 1'b0;
        w_st_wdata   = '0;
        w_mx_we      = 1'b0;
        w_mx_re      = 1'b0;
        w_mx_wdata   = '0;
        w_bn_we      = 1'b0;
        w_bn_re      = 1'b0;
        w_bn_wdata   = w_bn_cur + VALUE_W'(1);
        w_bin_raddr  = w_bin_idx;
        w_slot_waddr = w_slot_idx;
        w_div_start  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_st_we      = 1'b1;
                w_mx_we      = 1'b1;
                w_slot_waddr = r_clr;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_FETCH: begin
                w_st_re     = 1'b1;
                w_mx_re     = 1'b1;
                w_bn_re     = 1'b1;
                w_bin_raddr = w_sel_idx;
            end
            S_EVAL: begin
                if (t_cmd'(r_cmd) == CMD_START && r_slot_ok) begin
                    w_st_we    = 1'b1;
                    w_st_wdata = {1'b1, r_stamp};
                end else if (t_cmd'(r_cmd) == CMD_END && w_end_ok) begin
                    // drop the pending mark and start the divide
                    w_st_we     = 1'b1;
                    w_st_wdata  = {1'b0, w_st_rdata[STAMP_W-1:0]};
                    w_div_start = 1'b1;
                end
            end
            S_BINRD: begin
                w_bn_re = 1'b1;
            end
            S_UPDATE: begin
                w_bn_we    = w_bin_ok;
                w_mx_we    = w_max_upd;
                w_mx_wdata = {1'b1, r_dur};
            end
            S_DIV, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Staging, bin valid marks and output register
    always_comb begin
        n_cmd      = r_cmd;
        n_slot     = r_slot;
        n_stamp    = r_stamp;
        n_sel      = r_sel;
        n_slot_ok  = r_slot_ok;
        n_sel_ok   = r_sel_ok;
        n_status   = r_status;
        n_dur      = r_dur;
        n_bin      = r_bin;
        n_rv       = r_rv;
        n_vv       = r_vv;
        n_clr      = r_clr;
        n_bin_vld  = r_bin_vld;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_dur    = r_o_dur;
        n_o_bin    = r_o_bin;
        n_o_rv     = r_o_rv;
        n_o_vv     = r_o_vv;

        if (r_state == S_CLEAR) begin
            n_clr = r_clr + 1'b1;
        end

        // Capture a new request
        if (w_accept) begin
            n_cmd     = i_req.cmd;
            n_slot    = i_req.slot;
            n_stamp   = i_req.stamp_ns;
            n_sel     = i_req.bin_select;
            n_slot_ok = ({9'd0, i_req.slot} < 17'(SLOTS));
            n_sel_ok  = ({2'd0, i_req.bin_select} < 7'(BINS));
            n_status  = ST_OK;
            n_dur     = '0;
            n_bin     = '0;
            n_rv      = '0;
            n_vv      = 1'b0;
        end

        // Resolve the request once memory data is back
        if (r_state == S_EVAL) begin
            case (t_cmd'(r_cmd))
                CMD_END: begin
                    if (!w_end_ok) n_status = ST_NO_START;
                end
                CMD_RD_BIN: begin
                    if (r_sel_ok) begin
                        n_rv = r_bin_vld[w_sel_idx] ? w_bn_rdata : '0;
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
                CMD_RD_MAX: begin
                    if (r_slot_ok && w_mx_rdata[DUR_W]) begin
                        n_rv = VALUE_W'(w_mx_rdata[DUR_W-1:0]);
                        n_vv = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Take the quotient and its bin
        if (r_state == S_DIV && w_div.done) begin
            n_dur = w_div.quot[DUR_W-1:0];
            n_bin = w_div.msb;
        end

        if (r_state == S_BINRD && !w_bin_ok) begin
            n_status = ST_RANGE;
        end

        if (r_state == S_UPDATE && w_bin_ok) begin
            n_bin_vld[w_bin_idx] = 1'b1;
        end

        // Hand over to the output register
        if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end
        if (w_load) begin
            n_o_valid  = 1'b1;
            n_o_status = r_status;
            n_o_dur    = r_dur;
            n_o_bin    = r_bin;
            n_o_rv     = r_rv;
            n_o_vv     = r_vv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_bin_vld <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_bin_vld <= n_bin_vld;
            r_o_valid <= n_o_valid;
        end
        r_cmd      <= n_cmd;
        r_slot     <= n_slot;
        r_stamp    <= n_stamp;
        r_sel      <= n_sel;
        r_slot_ok  <= n_slot_ok;
        r_sel_ok   <= n_sel_ok;
        r_status   <= n_status;
        r_dur      <= n_dur;
        r_bin      <= n_bin;
        r_rv       <= n_rv;
        r_vv       <= n_vv;
        r_o_status <= n_o_status;
        r_o_dur    <= n_o_dur;
        r_o_bin    <= n_o_bin;
        r_o_rv     <= n_o_rv;
        r_o_vv     <= n_o_vv;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.duration_us = r_o_dur;
    assign o_rsp.bin_index   = r_o_bin;
    assign o_rsp.read_value  = r_o_rv;
    assign o_rsp.value_valid = r_o_vv;

    // Start timestamps with pending mark on top
    llh_ram #(.WIDTH(STW), .DEPTH(SLOTS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_st_wdata),
        .i_re    (w_st_re),
        .i_raddr (w_slot_idx),
        .o_rdata (w_st_rdata)
    );

    // Slot maxima with present mark on top
    llh_ram #(.WIDTH(MXW), .DEPTH(SLOTS)) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (w_mx_we),
        .i_waddr (w_slot_waddr),
        .i_wdata (w_mx_wdata),
        .i_re    (w_mx_re),
        .i_raddr (w_slot_idx),
        .o_rdata (w_mx_rdata)
    );

    // Histogram bin counters
    llh_ram #(.WIDTH(VALUE_W), .DEPTH(BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_bn_we),
        .i_waddr (w_bin_idx),
        .i_wdata (w_bn_wdata),
        .i_re    (w_bn_re),
        .i_raddr (w_bin_raddr),
        .o_rdata (w_bn_rdata)
    );

    // Divide-by-1000 unit
    llh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_diff),
        .o_res      (w_div)
    );

    // A divide completes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divide finished outside the divide state");

    // No request is taken during the clearing sweep
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !i_req.ready)
        else $error("request accepted during clearing sweep");

    // A non-zero bin index is the position of the duration's leading one
    a_bin_is_log2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.bin_index != '0) |->
        ((o_rsp.duration_us >> o_rsp.bin_index) == DUR_W'(1)))
        else $error("bin index does not match duration");

    // A counter is written only for an in-range bin
    a_bin_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bn_we |-> ({1'b0, r_bin} < (BIN_W+1)'(BINS)) && r_state == S_UPDATE)
        else $error("bin counter written out of range");

endmodule

// ===== design/llh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module llh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/llh_div.sv =====
// Byte-serial divide-by-1000 unit that also finds the quotient's leading one.
`timescale 1ns / 1ps

module llh_div import llh_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STAMP_W-1:0] i_dividend,
    output t_div_res           o_res
);

    // Eight quotient bits per step. floor(t/1000) = floor(floor(t/8)/125), and
    // 33555 = ceil(2^22/125) gives the exact quotient for every partial below 2^15.
    localparam int DIG_W    = 8;
    localparam int CNT_W    = 3;
    localparam int DROP_W   = 3;
    localparam int PART_W   = REM_W + DIG_W;
    localparam int Y_W      = PART_W - DROP_W;
    localparam int PROD_W   = Y_W + 16;
    localparam int RECIP_SH = 22;
    localparam logic [PROD_W-1:0] RECIP_125  = PROD_W'(33555);
    localparam logic [CNT_W-1:0]  LAST_DIGIT = CNT_W'(STAMP_W / DIG_W - 1);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [STAMP_W-1:0] r_quot, n_quot;
    logic [BIN_W-1:0]   r_msb, n_msb;
    logic               r_seen, n_seen;
    logic [PART_W-1:0]  w_part;
    logic [PROD_W-1:0]  w_prod;
    logic [DIG_W-1:0]   w_digit;
    logic [PART_W-1:0]  w_left;
    logic [2:0]         w_lead;

    // Position of the highest set bit of a quotient byte
    function automatic logic [2:0] lead_one(input logic [DIG_W-1:0] v);
        logic [2:0] pos;
        pos = '0;
        for (int i = 1; i < DIG_W; i++) begin
            if (v[i]) pos = 3'(i);
        end
        return pos;
    endfunction

    // Shared step: bring in one dividend byte, take its quotient digit and remainder
    assign w_part  = {r_rem, r_quot[STAMP_W-1 -: DIG_W]};
    assign w_prod  = PROD_W'(w_part[PART_W-1:DROP_W]) * RECIP_125;
    assign w_digit = w_prod[RECIP_SH +: DIG_W];
    assign w_left  = w_part - PART_W'(w_digit) * PART_W'(NS_PER_US);
    assign w_lead  = lead_one(w_digit);

    // Advance one quotient byte per cycle, most significant first
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_msb  = r_msb;
        n_seen = r_seen;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = LAST_DIGIT;
            n_rem  = '0;
            n_quot = i_dividend;
            n_msb  = '0;
            n_seen = 1'b0;
        end else if (r_busy) begin
            n_rem  = w_left[REM_W-1:0];
            n_quot = {r_quot[STAMP_W-DIG_W-1:0], w_digit};
            if (w_digit != '0 && !r_seen) begin
                n_msb  = {r_cnt, w_lead};
                n_seen = 1'b1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_msb  <= n_msb;
        r_seen <= n_seen;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.msb  = r_msb;

endmodule
